[hdl/lsmc_pkg.sv]
package lsmc_pkg;

   localparam int unsigned TimeoutWidth = 32;
   localparam logic [TimeoutWidth-1:0] DefaultTimeoutMs = 32'd10000;
   localparam int unsigned AddrWidth = 4;
   localparam int unsigned DataWidth = 32;

   typedef enum logic [2:0] {
      FUNC_TICK  = 3'd0,
      FUNC_WRITE = 3'd1,
      FUNC_STOP  = 3'd2,
      FUNC_RESET = 3'd3,
      FUNC_READ  = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      STATUS_SUCCESS  = 2'd0,
      STATUS_TIMEOUT  = 2'd1,
      STATUS_HW_FAULT = 2'd2,
      STATUS_INVALID  = 2'd3
   } status_type;

   // POS_MIN doubles as the empty position of every non-read beat
   typedef enum logic [1:0] {
      POS_MIN     = 2'd0,
      POS_MAX     = 2'd1,
      POS_UNKNOWN = 2'd2
   } pos_type;

   typedef enum logic [1:0] {
      REG_TIMEOUT_MS = 2'd0,
      REG_MIN_POLAR  = 2'd1,
      REG_MAX_POLAR  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] write_value;
      logic               min_end_level;
      logic               max_end_level;
   } req_type;

   typedef struct packed {
      logic       motor_forward;
      logic       motor_backward;
      status_type status;
      pos_type    position;
   } rsp_type;

   typedef struct packed {
      logic [TimeoutWidth-1:0] timeout_ms;
      logic                    min_end_active_high;
      logic                    max_end_active_high;
   } cfg_type;

endpackage

[hdl/lsmc_csr.sv]
module lsmc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [lsmc_pkg::AddrWidth-1:0]   paddr,
   input  logic [lsmc_pkg::DataWidth-1:0]   pwdata,
   output logic [lsmc_pkg::DataWidth-1:0]   prdata,
   output logic                             pready,
   output lsmc_pkg::cfg_type                cfg
);
   import lsmc_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[AddrWidth-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms          <= DefaultTimeoutMs;
         cfg_ff.min_end_active_high <= 1'b1;
         cfg_ff.max_end_active_high <= 1'b1;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TIMEOUT_MS: cfg_ff.timeout_ms          <= pwdata[TimeoutWidth-1:0];
            REG_MIN_POLAR:  cfg_ff.min_end_active_high <= pwdata[0];
            REG_MAX_POLAR:  cfg_ff.max_end_active_high <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_idx)
         REG_TIMEOUT_MS: prdata = DataWidth'(cfg_ff.timeout_ms);
         REG_MIN_POLAR:  prdata = DataWidth'(cfg_ff.min_end_active_high);
         REG_MAX_POLAR:  prdata = DataWidth'(cfg_ff.max_end_active_high);
         default:        prdata = '0;
      endcase
   end

endmodule

[hdl/lsmc_core.sv]
module lsmc_core (
   input  logic              clock,
   input  logic              reset,
   input  lsmc_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  lsmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsmc_pkg::rsp_type rsp_data
);
   import lsmc_pkg::*;

   typedef enum logic [1:0] {
      MS_IDLE   = 2'd0,
      MS_TO_MIN = 2'd1,
      MS_TO_MAX = 2'd2,
      MS_FAULT  = 2'd3
   } motion_type;

   motion_type              motion_ff, motion_in, halted;
   pos_type                 last_pos_ff, last_pos_in;
   logic [TimeoutWidth-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   req_type                 item_ff;
   logic                    item_valid_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff;
   logic                    advance;
   logic                    min_act, max_act, reached;

   // item moves to the result register when that register is free or drained
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign min_act = item_ff.min_end_level == cfg.min_end_active_high;
   assign max_act = item_ff.max_end_level == cfg.max_end_active_high;
   assign reached = (motion_ff == MS_TO_MIN) ? min_act : max_act;
   assign halted  = (motion_ff == MS_FAULT) ? MS_FAULT : MS_IDLE;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;

   always_comb begin
      motion_in       = motion_ff;
      last_pos_in     = last_pos_ff;
      elapsed_in      = elapsed_ff;
      rsp_in.status   = STATUS_SUCCESS;
      rsp_in.position = POS_MIN;
      unique case (func_type'(item_ff.func))
         FUNC_TICK: begin
            if (motion_ff == MS_TO_MIN || motion_ff == MS_TO_MAX) begin
               if (reached) begin
                  last_pos_in = (motion_ff == MS_TO_MIN) ? POS_MIN : POS_MAX;
                  motion_in   = MS_IDLE;
               end else begin
                  elapsed_in = elapsed_inc;
                  if (elapsed_inc > cfg.timeout_ms) begin
                     motion_in   = MS_FAULT;
                     last_pos_in = POS_UNKNOWN;
                  end
               end
            end
         end
         FUNC_WRITE: begin
            if (item_ff.write_value == 32'sd0) begin
               motion_in = halted;
               if (!min_act) begin
                  motion_in   = MS_TO_MIN;
                  last_pos_in = POS_UNKNOWN;
                  elapsed_in  = '0;
               end
            end else if (item_ff.write_value == 32'sd1) begin
               motion_in = halted;
               if (!max_act) begin
                  motion_in   = MS_TO_MAX;
                  last_pos_in = POS_UNKNOWN;
                  elapsed_in  = '0;
               end
            end else begin
               rsp_in.status = STATUS_INVALID;
            end
         end
         FUNC_STOP: motion_in = halted;
         FUNC_RESET: begin
            motion_in   = MS_IDLE;
            last_pos_in = POS_UNKNOWN;
         end
         FUNC_READ: begin
            priority if (motion_ff == MS_FAULT) rsp_in.status = STATUS_TIMEOUT;
            else if (min_act && max_act)        rsp_in.status = STATUS_HW_FAULT;
            else if (min_act)                   rsp_in.position = POS_MIN;
            else if (max_act)                   rsp_in.position = POS_MAX;
            else                                rsp_in.position = last_pos_ff;
         end
         default: rsp_in.status = STATUS_INVALID;
      endcase
      rsp_in.motor_forward  = motion_in == MS_TO_MAX;
      rsp_in.motor_backward = motion_in == MS_TO_MIN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         motion_ff     <= MS_IDLE;
         last_pos_ff   <= POS_UNKNOWN;
         elapsed_ff    <= '0;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            item_valid_ff <= 1'b1;
         end else if (advance) begin
            item_valid_ff <= 1'b0;
         end
         if (advance) begin
            motion_ff    <= motion_in;
            last_pos_ff  <= last_pos_in;
            elapsed_ff   <= elapsed_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

[hdl/limit_switch_motor_controller.sv]
// Limit-switch motor controller. Takes one beat per clock while results drain: a beat is
// captured in an input register, decoded against the motion state and the end-switch levels
// in combinational logic, and lands in a result register, so each result beat passes the
// input register and then the result register, and a new beat can enter every cycle while
// results keep draining. The path that sets the clock is the 32-bit saturating
// elapsed-time increment and its compare against timeout_ms. Configuration registers sit
// at byte addresses 0 (timeout_ms), 4 (min_end_active_high) and 8 (max_end_active_high);
// write them only while idle.
module limit_switch_motor_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lsmc_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lsmc_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [lsmc_pkg::AddrWidth-1:0] paddr,
   input  logic [lsmc_pkg::DataWidth-1:0] pwdata,
   output logic [lsmc_pkg::DataWidth-1:0] prdata,
   output logic                           pready
);
   import lsmc_pkg::*;

   cfg_type cfg;

   lsmc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lsmc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/lsmc_checker.sv]
module lsmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input lsmc_pkg::rsp_type rsp_data
);
   import lsmc_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.motor_forward && rsp_data.motor_backward))
      else $error("both drive directions on");

   // a failed beat carries only the empty position, POS_MIN
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_SUCCESS |-> rsp_data.position == POS_MIN)
      else $error("position set on a failing beat");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind limit_switch_motor_controller lsmc_checker u_lsmc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
